[design/bbw_pkg.sv]
// Package for the banked bitmap blit writer.
// Holds the shared constants, register indexes and the flag struct that travels
// from the front end through the queue to the back end. No dependencies.
package bbw_pkg;

    localparam int BANK_OFFSET_BITS_DEF = 16;
    localparam int COORD_BITS_DEF       = 12;

    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;

    localparam int ADDR_W      = 32;
    localparam int STRIDE_W    = 16;
    localparam int PIXEL_W     = 8;
    localparam int BANK_W      = 16;
    localparam int OFFSET_W    = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [REG_IDX_W-1:0] REG_DEST_BASE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_STRIDE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_X     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_START_Y     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BLIT_WIDTH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BLIT_HEIGHT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TRANSPARENT = 3'd6;

    // Classification of one pixel, decided by the front end.
    typedef struct packed {
        logic start;        // first pixel of a blit: reload the row start address
        logic row_end;      // last pixel of its row
        logic last;         // last pixel of the blit
        logic write_enable; // pixel is to be written
    } item_flags_t;

    localparam int FLAGS_W = $bits(item_flags_t);

endpackage

[design/bbw_regs.sv]
// Configuration register file of the blit writer with its APB-style port.
// Also registers the blit start address. Depends on bbw_pkg.
module bbw_regs
    import bbw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    output logic [STRIDE_W-1:0]     row_stride,
    output logic [ADDR_W-1:0]       start_address,
    output logic [COORD_BITS:0]     blit_width,
    output logic [COORD_BITS:0]     blit_height,
    output logic                    transparent_mode
);

    logic [ADDR_W-1:0]       base_reg;
    logic [STRIDE_W-1:0]     stride_reg;
    logic [COORD_BITS-1:0]   start_x_reg;
    logic [COORD_BITS-1:0]   start_y_reg;
    logic [COORD_BITS:0]     width_reg;
    logic [COORD_BITS:0]     height_reg;
    logic                    transparent_reg;
    logic [ADDR_W-1:0]       start_address_reg;
    logic [ADDR_W-1:0]       start_address_next;
    logic                    wr_en;
    logic [REG_IDX_W-1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= '0;
            stride_reg      <= '0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            width_reg       <= (COORD_BITS+1)'(1);
            height_reg      <= (COORD_BITS+1)'(1);
            transparent_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DEST_BASE:   base_reg        <= pwdata;
                REG_ROW_STRIDE:  stride_reg      <= pwdata[STRIDE_W-1:0];
                REG_START_X:     start_x_reg     <= pwdata[COORD_BITS-1:0];
                REG_START_Y:     start_y_reg     <= pwdata[COORD_BITS-1:0];
                REG_BLIT_WIDTH:  width_reg       <= pwdata[COORD_BITS:0];
                REG_BLIT_HEIGHT: height_reg      <= pwdata[COORD_BITS:0];
                REG_TRANSPARENT: transparent_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // Origin of the bitmap in the linear framebuffer, recomputed every cycle and
    // registered. Users change the configuration only while idle (not enforced).
    always_comb
    begin
        start_address_next = base_reg
                           + ADDR_W'(stride_reg) * ADDR_W'(start_y_reg)
                           + ADDR_W'(start_x_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_address_reg <= '0;
        else
            start_address_reg <= start_address_next;
    end

    always_comb
    begin
        case (reg_idx)
            REG_DEST_BASE:   prdata = base_reg;
            REG_ROW_STRIDE:  prdata = APB_DATA_W'(stride_reg);
            REG_START_X:     prdata = APB_DATA_W'(start_x_reg);
            REG_START_Y:     prdata = APB_DATA_W'(start_y_reg);
            REG_BLIT_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_BLIT_HEIGHT: prdata = APB_DATA_W'(height_reg);
            REG_TRANSPARENT: prdata = APB_DATA_W'(transparent_reg);
            default:         prdata = '0;
        endcase
    end

    assign row_stride       = stride_reg;
    assign start_address    = start_address_reg;
    assign blit_width       = width_reg;
    assign blit_height      = height_reg;
    assign transparent_mode = transparent_reg;

endmodule

[design/bbw_front.sv]
// Front end of the blit writer: accepts pixels, keeps the column and row
// counters and classifies each pixel. Depends on bbw_pkg.
module bbw_front
    import bbw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [PIXEL_W-1:0]      pixel,
    input  logic [COORD_BITS:0]     blit_width,
    input  logic [COORD_BITS:0]     blit_height,
    input  logic                    transparent_mode,
    input  logic                    q_full,
    output logic                    q_push,
    output item_flags_t             q_flags,
    output logic [PIXEL_W-1:0]      q_pixel,
    output logic [COORD_BITS-1:0]   q_column
);

    logic [COORD_BITS-1:0] column_reg;
    logic [COORD_BITS-1:0] column_next;
    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] row_next;
    logic [COORD_BITS-1:0] width_m1;
    logic [COORD_BITS-1:0] height_m1;
    logic                  row_end;
    logic                  blit_end;

    // Size minus one, with zero acting as one and oversize saturating.
    function automatic logic [COORD_BITS-1:0] size_m1(input logic [COORD_BITS:0] size);
        logic [COORD_BITS-1:0] res;
        if (size == '0)
            res = '0;
        else if (size[COORD_BITS])
            res = '1;
        else
            res = size[COORD_BITS-1:0] - COORD_BITS'(1);
        return res;
    endfunction

    assign width_m1  = size_m1(blit_width);
    assign height_m1 = size_m1(blit_height);
    assign row_end   = column_reg >= width_m1;
    assign blit_end  = row_end && (row_reg >= height_m1);

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        q_flags.start        = (column_reg == '0) && (row_reg == '0);
        q_flags.row_end      = row_end;
        q_flags.last         = blit_end;
        q_flags.write_enable = !(transparent_mode && (pixel == '0));
    end

    assign q_pixel  = pixel;
    assign q_column = column_reg;

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (q_push)
        begin
            if (blit_end)
            begin
                column_next = '0;
                row_next    = '0;
            end
            else if (row_end)
            begin
                column_next = '0;
                row_next    = row_reg + COORD_BITS'(1);
            end
            else
            begin
                column_next = column_reg + COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

[design/bbw_queue.sv]
// Short first-word-fall-through queue between the front and back ends of the
// blit writer. Depends on bbw_pkg for its depth.
module bbw_queue
    import bbw_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] head_data
);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

[design/bbw_back.sv]
// Back end of the blit writer: tracks the row start address, forms the
// linear address, splits it into bank and offset and holds the output register.
// Depends on bbw_pkg.
module bbw_back
    import bbw_pkg::*;
#(
    parameter int BANK_OFFSET_BITS = BANK_OFFSET_BITS_DEF,
    parameter int COORD_BITS       = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [STRIDE_W-1:0]     row_stride,
    input  logic [ADDR_W-1:0]       start_address,
    input  logic                    q_not_empty,
    output logic                    q_pop,
    input  item_flags_t             q_flags,
    input  logic [PIXEL_W-1:0]      q_pixel,
    input  logic [COORD_BITS-1:0]   q_column,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [BANK_W-1:0]       bank,
    output logic [OFFSET_W-1:0]     offset,
    output logic [PIXEL_W-1:0]      data,
    output logic                    write_enable,
    output logic                    last
);

    localparam logic [ADDR_W-1:0] OFFSET_MASK = (ADDR_W'(1) << BANK_OFFSET_BITS) - ADDR_W'(1);

    logic [ADDR_W-1:0]   row_addr_reg;
    logic [ADDR_W-1:0]   row_addr_next;
    logic [ADDR_W-1:0]   row_addr_cur;
    logic [ADDR_W-1:0]   pix_addr;
    logic                valid_reg;
    logic [BANK_W-1:0]   bank_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [PIXEL_W-1:0]  data_reg;
    logic                we_reg;
    logic                last_reg;

    assign q_pop = q_not_empty && (!valid_reg || out_ready);

    always_comb
    begin
        row_addr_cur  = q_flags.start ? start_address : row_addr_reg;
        pix_addr      = row_addr_cur + ADDR_W'(q_column);
        row_addr_next = row_addr_reg;
        if (q_pop)
        begin
            if (q_flags.row_end && !q_flags.last)
                row_addr_next = row_addr_cur + ADDR_W'(row_stride);
            else
                row_addr_next = row_addr_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_addr_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            row_addr_reg <= row_addr_next;
            if (q_pop)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bank_reg   <= BANK_W'(pix_addr >> BANK_OFFSET_BITS);
            offset_reg <= OFFSET_W'(pix_addr & OFFSET_MASK);
            data_reg   <= q_pixel;
            we_reg     <= q_flags.write_enable;
            last_reg   <= q_flags.last;
        end
    end

    assign out_valid    = valid_reg;
    assign bank         = bank_reg;
    assign offset       = offset_reg;
    assign data         = data_reg;
    assign write_enable = we_reg;
    assign last         = last_reg;

endmodule

[design/banked_bitmap_blit_writer.sv]
// Top level of the banked bitmap blit writer: register file, front end,
// queue and back end. Depends on bbw_pkg and the bbw_* modules.
//
// Usage: software programs the destination base address, row stride, start
// column and row, bitmap width and height and the transparency switch through
// the APB-style port while the block is idle. Source pixels then arrive in
// raster order on the input channel (in_valid, in_ready, pixel), one per
// transaction. For each pixel the output channel (out_valid, out_ready) carries
// one write transaction: bank, offset inside the 64 KiB window, data, a write
// enable that is low for a zero pixel in transparent mode, and last on the
// final pixel of the blit, after which the counters restart for the next blit.
// An accepted pixel is written into the queue and then, once the output
// register is free, into the output register. The block takes one pixel per
// cycle while the receiver does not stall. A four-entry queue separates the
// counting front end from the address back end; when the receiver stalls the
// output register holds, the queue fills, and in_ready falls once it is full.
// Reset clears the counters, the queue and the output valid, and restores the
// register reset values (width and height of one, everything else zero).
module banked_bitmap_blit_writer
    import bbw_pkg::*;
#(
    parameter int BANK_OFFSET_BITS = BANK_OFFSET_BITS_DEF,
    parameter int COORD_BITS       = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIXEL_W-1:0]    pixel,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BANK_W-1:0]     bank,
    output logic [OFFSET_W-1:0]   offset,
    output logic [PIXEL_W-1:0]    data,
    output logic                  write_enable,
    output logic                  last
);

    // One queue entry: classification flags, the pixel and its column.
    localparam int ITEM_W = FLAGS_W + PIXEL_W + COORD_BITS;

    logic [STRIDE_W-1:0]   row_stride;
    logic [ADDR_W-1:0]     start_address;
    logic [COORD_BITS:0]   blit_width;
    logic [COORD_BITS:0]   blit_height;
    logic                  transparent_mode;

    logic                  q_full;
    logic                  q_push;
    item_flags_t           push_flags;
    logic [PIXEL_W-1:0]    push_pixel;
    logic [COORD_BITS-1:0] push_column;
    logic [ITEM_W-1:0]     push_item;

    logic                  q_pop;
    logic                  q_not_empty;
    logic [ITEM_W-1:0]     head_item;
    item_flags_t           head_flags;
    logic [PIXEL_W-1:0]    head_pixel;
    logic [COORD_BITS-1:0] head_column;

    bbw_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .row_stride       (row_stride),
        .start_address    (start_address),
        .blit_width       (blit_width),
        .blit_height      (blit_height),
        .transparent_mode (transparent_mode)
    );

    // The front end counts columns and rows and marks blit start, row end
    // and blit end, so the back end only has to follow the flags.
    bbw_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pixel            (pixel),
        .blit_width       (blit_width),
        .blit_height      (blit_height),
        .transparent_mode (transparent_mode),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_flags          (push_flags),
        .q_pixel          (push_pixel),
        .q_column         (push_column)
    );

    assign push_item = {push_flags, push_pixel, push_column};

    bbw_queue #(
        .DATA_W (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (head_item)
    );

    assign {head_flags, head_pixel, head_column} = head_item;

    // The back end owns the running row start address and the output
    // register, which takes a new pixel when it is empty or its result is taken.
    bbw_back #(
        .BANK_OFFSET_BITS (BANK_OFFSET_BITS),
        .COORD_BITS       (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .row_stride    (row_stride),
        .start_address (start_address),
        .q_not_empty   (q_not_empty),
        .q_pop         (q_pop),
        .q_flags       (head_flags),
        .q_pixel       (head_pixel),
        .q_column      (head_column),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bank          (bank),
        .offset        (offset),
        .data          (data),
        .write_enable  (write_enable),
        .last          (last)
    );

endmodule
